### rtl/sorted_key_list_unit_macros.svh
// Assertion macros shared by the sorted key list RTL.
`ifndef SORTED_KEY_LIST_UNIT_MACROS_SVH
`define SORTED_KEY_LIST_UNIT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define SKL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define SKL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/skl_pkg.sv
// Types and constants for the sorted key list.
package skl_pkg;

    // Fixed field widths on the stream ports
    localparam int MODE_W     = 2;
    localparam int KEY_W      = 16;
    localparam int HANDLE_W   = 16;
    localparam int POS_W      = 9;
    localparam int STATUS_W   = 2;
    localparam int FILL_W     = 9;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT   = 2'd0,
        MODE_REMOVE   = 2'd1,
        MODE_GET      = 2'd2,
        MODE_CONTAINS = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_ENTRY = 2'd1,
        STATUS_FULL     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic eval;       // latch compare flags
        logic rd_ok;      // read index lies inside the list
        logic apply_ins;  // open a gap and write the new entry
        logic apply_rem;  // close the gap at the first equal key
    } t_cell_ctl;

    // Registered flags of one cell
    typedef struct packed {
        logic take;  // slot is empty or its key is >= the command key
        logic eq;    // slot is occupied and its key equals the command key
        logic rd;    // slot is the one addressed by a get
    } t_cell_flags;

endpackage

### rtl/skl_cell.sv
// One slot of the sorted list: compare against the broadcast key, shift with neighbors.
module skl_cell #(
    parameter int CAPACITY    = 256,
    parameter int KEY_BITS    = 16,
    parameter int HANDLE_BITS = 16,
    parameter int INDEX       = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  skl_pkg::t_cell_ctl                 i_ctl,
    input  logic [KEY_BITS-1:0]                i_cmd_key,
    input  logic [HANDLE_BITS-1:0]             i_cmd_handle,
    input  logic [$clog2(CAPACITY+1)-1:0]      i_count,
    input  logic [$clog2(CAPACITY)-1:0]        i_rd_index,
    input  logic                               i_left_take,
    input  logic [KEY_BITS-1:0]                i_left_key,
    input  logic [HANDLE_BITS-1:0]             i_left_handle,
    input  logic [KEY_BITS-1:0]                i_right_key,
    input  logic [HANDLE_BITS-1:0]             i_right_handle,
    output skl_pkg::t_cell_flags               o_flags,
    output logic [KEY_BITS-1:0]                o_key,
    output logic [HANDLE_BITS-1:0]             o_handle,
    output logic [KEY_BITS-1:0]                o_rd_key,
    output logic [HANDLE_BITS-1:0]             o_rd_handle
);
    import skl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic [KEY_BITS-1:0]    r_key;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [KEY_BITS-1:0]    n_key;
    logic [HANDLE_BITS-1:0] n_handle;
    t_cell_flags            r_flags;
    t_cell_flags            n_flags;
    logic                   w_occupied;
    logic                   w_ge;

    assign w_occupied = CW'(INDEX) < i_count;
    assign w_ge       = r_key >= i_cmd_key;

    // Latch compare flags while the command is evaluated
    always_comb begin
        n_flags = r_flags;
        if (i_ctl.eval) begin
            n_flags.take = !w_occupied || w_ge;
            n_flags.eq   = w_occupied && (r_key == i_cmd_key);
            n_flags.rd   = i_ctl.rd_ok && (i_rd_index == AW'(INDEX));
        end
    end

    // Shift right on insert, shift left on remove, else hold
    always_comb begin
        n_key    = r_key;
        n_handle = r_handle;
        if (i_ctl.apply_ins) begin
            if (i_left_take) begin
                n_key    = i_left_key;
                n_handle = i_left_handle;
            end else if (r_flags.take) begin
                n_key    = i_cmd_key;
                n_handle = i_cmd_handle;
            end
        end else if (i_ctl.apply_rem) begin
            if (r_flags.take && w_occupied) begin
                n_key    = i_right_key;
                n_handle = i_right_handle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_handle <= n_handle;
    end

    assign o_flags     = r_flags;
    assign o_key       = r_key;
    assign o_handle    = r_handle;
    assign o_rd_key    = r_flags.rd ? r_key : '0;
    assign o_rd_handle = r_flags.rd ? r_handle : '0;

endmodule

### rtl/sorted_key_list_unit.sv
// Sorted key list: a row of compare-and-shift cells kept in ascending key order.
// Each input passes a compare state, then an update state; the result is registered on leaving update.
// Items are handled one at a time; each needs the compare/update pass over the cell row.
// A new input is taken in the update cycle when the output register is free.
// Reset (i_rst_n low, synchronous) empties the list; stored entries are not cleared.
// No clearing pass: slots at or above the fill count are never read.
`include "sorted_key_list_unit_macros.svh"

module sorted_key_list_unit #(
    parameter int CAPACITY    = 256,
    parameter int KEY_BITS    = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tuser: mode[1:0]
    input  logic [skl_pkg::MODE_W-1:0]          i_s_tuser,
    // tdata: key[15:0], handle[31:16], position[40:32], zero pad[47:41]
    input  logic [skl_pkg::IN_DATA_W-1:0]       i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tuser: status[1:0]
    output logic [skl_pkg::STATUS_W-1:0]        o_m_tuser,
    // tdata: out_key[15:0], out_handle[31:16], present[32], fill[41:33], zero pad[47:42]
    output logic [skl_pkg::OUT_DATA_W-1:0]      o_m_tdata
);
    import skl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int IW = ((CW > POS_W) ? CW : POS_W) + 1;

    // Control and command registers
    t_state                 r_state;
    t_state                 n_state;
    t_mode                  r_mode;
    logic [KEY_BITS-1:0]    r_key;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [POS_W-1:0]       r_pos;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;

    // Output register
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [KEY_W-1:0]       r_out_key;
    logic [HANDLE_W-1:0]    r_out_handle;
    logic                   r_out_present;
    logic [FILL_W-1:0]      r_out_fill;
    t_status                n_out_status;
    logic                   n_out_present;

    logic                   w_in_xfer;
    logic                   w_out_free;
    logic                   w_fire;
    logic                   w_full;
    logic                   w_found;
    logic [IW-1:0]          w_idx;
    logic                   w_rd_ok;
    t_cell_ctl              w_ctl;
    logic [31:0]            w_in_key32;
    logic [31:0]            w_in_handle32;
    logic [31:0]            w_rd_key32;
    logic [31:0]            w_rd_handle32;
    logic [KEY_BITS-1:0]    w_rd_key;
    logic [HANDLE_BITS-1:0] w_rd_handle;

    // Cell row wiring
    t_cell_flags            w_flags      [CAPACITY];
    logic [KEY_BITS-1:0]    w_cell_key   [CAPACITY];
    logic [HANDLE_BITS-1:0] w_cell_handle[CAPACITY];
    logic [KEY_BITS-1:0]    w_cell_rdk   [CAPACITY];
    logic [HANDLE_BITS-1:0] w_cell_rdh   [CAPACITY];
    logic [CAPACITY-1:0]    w_eq_hits;
    logic [CAPACITY-1:0]    w_rd_hits;

    // Handshake
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_fire     = (r_state == S_UPD) && w_out_free;
    assign o_s_tready = (r_state == S_IDLE) || w_fire;
    assign w_in_xfer  = i_s_tvalid && o_s_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_fire) n_state = w_in_xfer ? S_CMP : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the command on input transfer
    assign w_in_key32    = {16'b0, i_s_tdata[15:0]};
    assign w_in_handle32 = {16'b0, i_s_tdata[31:16]};

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_mode   <= t_mode'(i_s_tuser);
            r_key    <= w_in_key32[KEY_BITS-1:0];
            r_handle <= w_in_handle32[HANDLE_BITS-1:0];
            r_pos    <= i_s_tdata[40:32];
        end
    end

    // Resolve the get index, counting back from the end when negative
    always_comb begin
        w_idx = {{(IW-POS_W){r_pos[POS_W-1]}}, r_pos};
        if (r_pos[POS_W-1]) w_idx = w_idx + IW'(r_count);
    end
    assign w_rd_ok = !w_idx[IW-1] && (w_idx < IW'(r_count));

    assign w_full  = r_count >= CW'(CAPACITY);
    assign w_found = |w_eq_hits;

    // Cell control outputs
    always_comb begin
        w_ctl           = '0;
        w_ctl.eval      = (r_state == S_CMP);
        w_ctl.rd_ok     = w_rd_ok;
        w_ctl.apply_ins = w_fire && (r_mode == MODE_INSERT) && !w_full;
        w_ctl.apply_rem = w_fire && (r_mode == MODE_REMOVE) && w_found;
    end

    // Row of cells
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic                   w_left_take;
        logic [KEY_BITS-1:0]    w_left_key;
        logic [HANDLE_BITS-1:0] w_left_handle;
        logic [KEY_BITS-1:0]    w_right_key;
        logic [HANDLE_BITS-1:0] w_right_handle;

        if (gi == 0) begin : g_first
            assign w_left_take   = 1'b0;
            assign w_left_key    = '0;
            assign w_left_handle = '0;
        end else begin : g_mid_l
            assign w_left_take   = w_flags[gi-1].take;
            assign w_left_key    = w_cell_key[gi-1];
            assign w_left_handle = w_cell_handle[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign w_right_key    = '0;
            assign w_right_handle = '0;
        end else begin : g_mid_r
            assign w_right_key    = w_cell_key[gi+1];
            assign w_right_handle = w_cell_handle[gi+1];
        end

        skl_cell #(
            .CAPACITY   (CAPACITY),
            .KEY_BITS   (KEY_BITS),
            .HANDLE_BITS(HANDLE_BITS),
            .INDEX      (gi)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_cmd_key     (r_key),
            .i_cmd_handle  (r_handle),
            .i_count       (r_count),
            .i_rd_index    (w_idx[AW-1:0]),
            .i_left_take   (w_left_take),
            .i_left_key    (w_left_key),
            .i_left_handle (w_left_handle),
            .i_right_key   (w_right_key),
            .i_right_handle(w_right_handle),
            .o_flags       (w_flags[gi]),
            .o_key         (w_cell_key[gi]),
            .o_handle      (w_cell_handle[gi]),
            .o_rd_key      (w_cell_rdk[gi]),
            .o_rd_handle   (w_cell_rdh[gi])
        );

        assign w_eq_hits[gi] = w_flags[gi].eq;
        assign w_rd_hits[gi] = w_flags[gi].rd;
    end

    // Merge the selected slot's entry; at most one cell drives nonzero data
    always_comb begin
        w_rd_key    = '0;
        w_rd_handle = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd_key    = w_rd_key | w_cell_rdk[i];
            w_rd_handle = w_rd_handle | w_cell_rdh[i];
        end
    end
    assign w_rd_key32    = 32'(w_rd_key);
    assign w_rd_handle32 = 32'(w_rd_handle);

    // Fill count after the operation
    always_comb begin
        n_count = r_count;
        if (w_ctl.apply_ins) n_count = r_count + CW'(1);
        else if (w_ctl.apply_rem) n_count = r_count - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Result status and presence
    always_comb begin
        n_out_status  = STATUS_OK;
        n_out_present = 1'b0;
        case (r_mode)
            MODE_INSERT: begin
                if (w_full) n_out_status = STATUS_FULL;
            end
            MODE_REMOVE: begin
                if (!w_found) n_out_status = STATUS_NO_ENTRY;
            end
            MODE_GET: begin
                if (!w_rd_ok) n_out_status = STATUS_NO_ENTRY;
            end
            MODE_CONTAINS: begin
                n_out_present = w_found;
            end
            default: begin
                n_out_status = STATUS_OK;
            end
        endcase
    end

    // Output register: load on fire, drop valid on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_status  <= n_out_status;
            r_out_present <= n_out_present;
            r_out_fill    <= FILL_W'(n_count);
            if ((r_mode == MODE_GET) && w_rd_ok) begin
                r_out_key    <= w_rd_key32[KEY_W-1:0];
                r_out_handle <= w_rd_handle32[HANDLE_W-1:0];
            end else begin
                r_out_key    <= '0;
                r_out_handle <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {6'b0, r_out_fill, r_out_present, r_out_handle, r_out_key};

    // Checks
    `SKL_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "fill count above capacity")
    `SKL_ASSERT_NEXT(a_xfer_to_cmp, i_clk, i_rst_n, w_in_xfer, r_state == S_CMP, "accepted item did not start compare")
    `SKL_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_ctl.apply_ins, r_count == $past(r_count) + CW'(1), "insert did not grow the list")
    `SKL_ASSERT_NOW(a_one_read_slot, i_clk, i_rst_n, 1'b1, $onehot0(w_rd_hits), "more than one slot selected for read")
    `SKL_ASSERT_NOW(a_full_status, i_clk, i_rst_n, r_out_valid && (r_out_status == STATUS_FULL), r_count == CW'(CAPACITY), "full reported below capacity")

endmodule

### bench/sorted_key_list_checker.sv
// Checker for the sorted key list: predicts each result and compares transfers on the output.
`timescale 1ns / 100ps

module sorted_key_list_checker #(
    parameter int CAPACITY = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    // tuser: mode[1:0]
    input  logic [skl_pkg::MODE_W-1:0]        i_s_tuser,
    // tdata: key[15:0], handle[31:16], position[40:32], zero pad[47:41]
    input  logic [skl_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    // tuser: status[1:0]
    input  logic [skl_pkg::STATUS_W-1:0]      i_m_tuser,
    // tdata: out_key[15:0], out_handle[31:16], present[32], fill[41:33], zero pad[47:42]
    input  logic [skl_pkg::OUT_DATA_W-1:0]    i_m_tdata,
    output int                                o_mismatches,
    output int                                o_pending,
    output int                                o_checked,
    output int                                o_full_refusals
);

    import skl_pkg::*;

    typedef struct {
        t_status     status;
        logic [15:0] key;
        logic [15:0] handle;
        logic        present;
        logic [8:0]  fill;
    } t_list_result;

    // Shadow copy of the list contents, ascending key order
    logic [15:0] shadow_keys    [CAPACITY];
    logic [15:0] shadow_handles [CAPACITY];
    int          shadow_count;

    t_list_result expected_results[$];
    t_list_result observed;
    t_list_result predicted;

    // Find the first slot whose key is >= k; shadow_count if there is none
    function automatic int first_slot_not_below(input logic [15:0] k);
        int i;
        i = 0;
        while (i < shadow_count && shadow_keys[i] < k) i++;
        return i;
    endfunction

    // Apply one list operation to the shadow copy and form its result
    task automatic apply_list_op(input t_mode op, input logic [15:0] k,
                                 input logic [15:0] h, input logic signed [8:0] pos,
                                 output t_list_result res);
        int slot;
        int idx;
        int i;
        res.status  = STATUS_OK;
        res.key     = '0;
        res.handle  = '0;
        res.present = 1'b0;
        case (op)
            MODE_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    res.status = STATUS_FULL;
                end else begin
                    slot = first_slot_not_below(k);
                    for (i = shadow_count; i > slot; i--) begin
                        shadow_keys[i]    = shadow_keys[i-1];
                        shadow_handles[i] = shadow_handles[i-1];
                    end
                    shadow_keys[slot]    = k;
                    shadow_handles[slot] = h;
                    shadow_count++;
                end
            end
            MODE_REMOVE: begin
                slot = first_slot_not_below(k);
                if (slot >= shadow_count || shadow_keys[slot] != k) begin
                    res.status = STATUS_NO_ENTRY;
                end else begin
                    for (i = slot; i + 1 < shadow_count; i++) begin
                        shadow_keys[i]    = shadow_keys[i+1];
                        shadow_handles[i] = shadow_handles[i+1];
                    end
                    shadow_count--;
                end
            end
            MODE_GET: begin
                // Negative index counts back from the end of the list
                idx = int'(pos);
                if (idx < 0) idx += shadow_count;
                if (idx < 0 || idx >= shadow_count) begin
                    res.status = STATUS_NO_ENTRY;
                end else begin
                    res.key    = shadow_keys[idx];
                    res.handle = shadow_handles[idx];
                end
            end
            default: begin
                slot = first_slot_not_below(k);
                res.present = (slot < shadow_count) && (shadow_keys[slot] == k);
            end
        endcase
        res.fill = shadow_count[8:0];
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_results.delete();
            o_mismatches    <= 0;
            o_checked       <= 0;
            o_full_refusals <= 0;
        end else begin
            // Compare an output transfer against the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                observed.status  = t_status'(i_m_tuser);
                observed.key     = i_m_tdata[15:0];
                observed.handle  = i_m_tdata[31:16];
                observed.present = i_m_tdata[32];
                observed.fill    = i_m_tdata[41:33];
                if (expected_results.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("%0t: result transfer with no result outstanding", $realtime);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    predicted = expected_results.pop_front();
                    if (observed.status !== predicted.status ||
                        observed.key !== predicted.key ||
                        observed.handle !== predicted.handle ||
                        observed.present !== predicted.present ||
                        observed.fill !== predicted.fill) begin
                        if (o_mismatches < 10)
                            $display("%0t: result %0d: expected status=%0d key=%h ",
                                     $realtime, o_checked, predicted.status, predicted.key,
                                     "handle=%h present=%b fill=%0d, got status=%0d ",
                                     predicted.handle, predicted.present, predicted.fill,
                                     observed.status,
                                     "key=%h handle=%h present=%b fill=%0d",
                                     observed.key, observed.handle, observed.present,
                                     observed.fill);
                        o_mismatches <= o_mismatches + 1;
                    end
                    if (predicted.status == STATUS_FULL)
                        o_full_refusals <= o_full_refusals + 1;
                    o_checked <= o_checked + 1;
                end
            end
            // Predict the result of an input transfer
            if (i_s_tvalid && i_s_tready) begin
                apply_list_op(t_mode'(i_s_tuser), i_s_tdata[15:0], i_s_tdata[31:16],
                              i_s_tdata[40:32], predicted);
                expected_results.push_back(predicted);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

### bench/tb_sorted_key_list_unit.sv
// Testbench top for the sorted key list: stimulus, handshake pressure and verdict.
`timescale 1ns / 100ps

module tb_sorted_key_list_unit;

    import skl_pkg::*;

    localparam int CAPACITY       = 256;
    localparam int CLK_PERIOD     = 12;
    localparam int RANDOM_PER_PHASE = 400;
    localparam int TIMEOUT_CYCLES = 300_000;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   s_tvalid   = 1'b0;
    logic                   s_tready;
    logic [MODE_W-1:0]      s_tuser    = '0;
    logic [IN_DATA_W-1:0]   s_tdata    = '0;
    logic                   m_tvalid;
    logic                   m_tready   = 1'b0;
    logic [STATUS_W-1:0]    m_tuser;
    logic [OUT_DATA_W-1:0]  m_tdata;

    int mismatches;
    int pending;
    int checked;
    int full_refusals;

    int tx_idle_pct = 26;
    int rx_idle_pct = 85;
    int sent_per_mode[4];

    sorted_key_list_unit #(
        .CAPACITY    (CAPACITY),
        .KEY_BITS    (16),
        .HANDLE_BITS (16)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tuser  (s_tuser),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tuser  (m_tuser),
        .o_m_tdata  (m_tdata)
    );

    sorted_key_list_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tuser       (s_tuser),
        .i_s_tdata       (s_tdata),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tuser       (m_tuser),
        .i_m_tdata       (m_tdata),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_full_refusals (full_refusals)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Hold one item on the input until it transfers, after a random gap
    task automatic send_item(input t_mode op, input int k, input int h, input int pos);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, pos[8:0], h[15:0], k[15:0]};
        do @(posedge i_clk); while (!s_tready);
        sent_per_mode[op]++;
    endtask

    // Mostly a narrow key range so removes and lookups hit, plus extremes and full range
    function automatic int pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 60) return $urandom_range(63);
        if (r < 72) begin
            case ($urandom_range(5))
                0: return 0;
                1: return 1;
                2: return 16'h7FFF;
                3: return 16'h8000;
                4: return 16'hFFFE;
                default: return 16'hFFFF;
            endcase
        end
        return $urandom_range(16'hFFFF);
    endfunction

    function automatic int pick_position();
        int r;
        r = $urandom_range(99);
        if (r < 40) return $urandom_range(511);
        if (r < 70) return $urandom_range(31);
        return 512 - $urandom_range(32, 1);
    endfunction

    function automatic t_mode pick_mode(input int w_ins, input int w_rem, input int w_get);
        int r;
        r = $urandom_range(99);
        if (r < w_ins) return MODE_INSERT;
        if (r < w_ins + w_rem) return MODE_REMOVE;
        if (r < w_ins + w_rem + w_get) return MODE_GET;
        return MODE_CONTAINS;
    endfunction

    initial begin
        int phase;
        int n;
        int seg;
        int drain_cycles;
        t_mode op;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: every read and remove misses
        send_item(MODE_GET,      0,       0,       0);
        send_item(MODE_GET,      0,       0,       -1);
        send_item(MODE_REMOVE,   0,       0,       0);
        send_item(MODE_CONTAINS, 16'hFFFF, 0,      0);
        // Extremes and an equal key that must land before the older one
        send_item(MODE_INSERT,   16'hFFFF, 16'hFFFF, 0);
        send_item(MODE_INSERT,   0,        0,        0);
        send_item(MODE_INSERT,   16'h8000, 16'h1234, 0);
        send_item(MODE_INSERT,   16'h8000, 16'hABCD, 0);
        // Reads from both ends, in and out of range
        send_item(MODE_GET,      0, 0, 0);
        send_item(MODE_GET,      0, 0, -1);
        send_item(MODE_GET,      0, 0, 1);
        send_item(MODE_GET,      0, 0, -4);
        send_item(MODE_GET,      0, 0, 4);
        send_item(MODE_GET,      0, 0, -5);
        send_item(MODE_GET,      0, 0, 255);
        send_item(MODE_GET,      0, 0, -256);
        send_item(MODE_CONTAINS, 16'h8000, 0, 0);
        send_item(MODE_CONTAINS, 16'h7FFF, 0, 0);
        // Remove takes the first of the equal keys
        send_item(MODE_REMOVE,   16'h8000, 0, 0);
        send_item(MODE_GET,      0, 0, 1);
        send_item(MODE_REMOVE,   16'h1111, 0, 0);
        send_item(MODE_REMOVE,   16'hFFFF, 0, 0);
        send_item(MODE_GET,      0, 0, -1);

        // Random part: fill to full, drain, then a mix; three pressure phases
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 26; rx_idle_pct = 85; end
                1: begin tx_idle_pct = 85; rx_idle_pct = 26; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                seg = (phase * RANDOM_PER_PHASE + n) % 600;
                if (seg < 300) op = pick_mode(94, 2, 2);
                else if (seg < 500) op = pick_mode(5, 75, 10);
                else op = pick_mode(25, 25, 25);
                send_item(op, pick_key(), $urandom_range(16'hFFFF), pick_position());
            end
        end
        s_tvalid <= 1'b0;

        // Wait out the results still in flight, then the block's latency
        drain_cycles = 0;
        while (pending != 0 && drain_cycles < 5000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (8) @(posedge i_clk);

        $display("Sent %0d operations: %0d insert, %0d remove, %0d get, %0d contains.",
                 sent_per_mode[0] + sent_per_mode[1] + sent_per_mode[2] + sent_per_mode[3],
                 sent_per_mode[0], sent_per_mode[1], sent_per_mode[2], sent_per_mode[3]);
        $display("Checked %0d results; %0d inserts refused on a full list.",
                 checked, full_refusals);
        if (pending != 0)
            $display("%0d predicted results never arrived", pending);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Run timed out");
        $display("Mismatches found");
        $finish;
    end

endmodule

### sorted_key_list_unit.f
+incdir+rtl
rtl/skl_pkg.sv
rtl/skl_cell.sv
rtl/sorted_key_list_unit.sv
bench/sorted_key_list_checker.sv
bench/tb_sorted_key_list_unit.sv
